### hw/rtl/plist_pkg.sv
// shared types and constants of the positional list engine
`default_nettype none
package plist_pkg;

   // default depth of the entry memory
   localparam int unsigned PLIST_CAPACITY = 64;

   // fixed field widths
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned STATUS_W = 2;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_INS_FIRST = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INS_LAST  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INS_AT    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_FIRST = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DEL_LAST  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DEL_AT    = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_COUNT     = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_WALK      = 3'd7;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SHIFT_LAST,
      ST_PUT,
      ST_RESP,
      ST_WALK_RD,
      ST_WALK_OUT
   } plist_state_type;

endpackage
`default_nettype wire

### hw/rtl/plist_mem.sv
// entry memory: one write port, one read port with registered read data
`default_nettype none
module plist_mem #(
   parameter int unsigned DEPTH = plist_pkg::PLIST_CAPACITY,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [AW-1:0]                wr_addr,
   input  wire logic [plist_pkg::VALUE_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [AW-1:0]                rd_addr,
   output logic      [plist_pkg::VALUE_W-1:0] rd_data
);
   import plist_pkg::*;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/positional_list_engine_core.sv
// Positional list engine: an ordered list of signed 32-bit values held packed in one
// single-port-per-direction memory. Each request on the req_ channel carries one
// function: insert first/last/at position, delete first/last/at position, count or
// walk. Every function but walk answers with one response on the rsp_ channel; a walk
// answers with one response per entry in list order, the final one marked by rsp_last
// (an empty list gives one response with no value).
// Count, rejected operations, insert last and delete last answer without moving
// entries. An insert or delete that moves entries shifts them one entry per cycle
// in a read-then-write pass over the memory. A walk reads and outputs each entry in
// turn, one memory read and one output load per entry, waiting on a stalled receiver.
// One request is worked on at a time; the next is taken once the response of the
// previous one sits in the output register, even while the receiver stalls.
// A stalled receiver holds the output register and the sequencer waits in front of it.
// Reset empties the list at once; memory contents need no clearing.
`default_nettype none
module positional_list_engine_core #(
   parameter int unsigned CAPACITY = plist_pkg::PLIST_CAPACITY
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [plist_pkg::FUNC_W-1:0]  req_func,
   input  wire logic signed [plist_pkg::VALUE_W-1:0] req_item_value,
   input  wire logic [plist_pkg::COUNT_W-1:0] req_position,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [plist_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                               rsp_has_value,
   output logic      [plist_pkg::COUNT_W-1:0] rsp_entry_count,
   output logic      [plist_pkg::STATUS_W-1:0] rsp_status,
   output logic                               rsp_last
);
   import plist_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   // sequencer and datapath registers
   plist_state_type      state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 op_ins_ff, op_ins_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic [AW-1:0]        stop_ff, stop_in;
   logic [AW-1:0]        put_idx_ff, put_idx_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;

   // output register
   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_has_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_last_ff;

   // memory port signals
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [VALUE_W-1:0]   mem_wr_data;
   logic                 mem_rd_en;
   logic [VALUE_W-1:0]   mem_rd_data;

   // output load controls
   logic                 out_free;
   logic                 rsp_load;
   logic [VALUE_W-1:0]   rsp_load_value;
   logic                 rsp_load_has;
   logic                 rsp_load_last;

   // request decode results
   plist_state_type      d_state;
   logic [COUNT_W-1:0]   d_count;
   logic                 d_ins;
   logic [AW-1:0]        d_rd_start;
   logic [AW-1:0]        d_stop;
   logic [AW-1:0]        d_put;
   logic [STATUS_W-1:0]  d_status;
   logic [COUNT_W-1:0]   idx7;
   logic [COUNT_W-1:0]   idx7_next;
   logic [COUNT_W-1:0]   count_m1;
   logic                 ins_pos_ok;
   logic                 del_pos_ok;
   logic                 list_full;
   logic                 req_take;
   logic                 walk_end;

   plist_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_end  = (rd_idx_ff == stop_ff);

   // position checks
   assign count_m1   = count_ff - COUNT_W'(1);
   assign list_full  = (count_ff == CAP_COUNT);
   assign ins_pos_ok = (req_position != '0)
                       && ({1'b0, req_position} <= ({1'b0, count_ff} + 8'd1));
   assign del_pos_ok = (req_position != '0) && (req_position <= count_ff);
   assign idx7_next  = idx7 + COUNT_W'(1);

   // request decode
   always_comb begin
      d_state    = ST_RESP;
      d_count    = count_ff;
      d_ins      = 1'b0;
      d_rd_start = '0;
      d_stop     = '0;
      d_put      = '0;
      d_status   = STAT_DONE;
      idx7       = '0;
      unique case (req_func) inside
         FUNC_INS_FIRST, FUNC_INS_LAST, FUNC_INS_AT: begin
            if (req_func == FUNC_INS_FIRST) begin
               idx7 = '0;
            end else if (req_func == FUNC_INS_LAST) begin
               idx7 = count_ff;
            end else begin
               idx7 = req_position - COUNT_W'(1);
            end
            if (req_func == FUNC_INS_AT && !ins_pos_ok) begin
               d_status = STAT_BAD;
            end else if (list_full) begin
               d_status = STAT_FULL;
            end else begin
               d_count    = count_ff + COUNT_W'(1);
               d_ins      = 1'b1;
               d_put      = idx7[AW-1:0];
               d_rd_start = count_m1[AW-1:0];
               d_stop     = idx7[AW-1:0];
               d_state    = (idx7 < count_ff) ? ST_SHIFT : ST_PUT;
            end
         end
         FUNC_DEL_FIRST, FUNC_DEL_LAST, FUNC_DEL_AT: begin
            if (req_func == FUNC_DEL_FIRST) begin
               idx7 = '0;
            end else if (req_func == FUNC_DEL_LAST) begin
               idx7 = count_m1;
            end else begin
               idx7 = req_position - COUNT_W'(1);
            end
            if (count_ff == '0 || (req_func == FUNC_DEL_AT && !del_pos_ok)) begin
               d_status = STAT_BAD;
            end else begin
               d_count    = count_m1;
               d_rd_start = idx7_next[AW-1:0];
               d_stop     = count_m1[AW-1:0];
               d_state    = (idx7 < count_m1) ? ST_SHIFT : ST_RESP;
            end
         end
         FUNC_COUNT: begin
            d_state = ST_RESP;
         end
         default: begin
            // walk
            d_rd_start = '0;
            d_stop     = count_m1[AW-1:0];
            d_state    = (count_ff == '0) ? ST_RESP : ST_WALK_RD;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = d_state;
            end
         end
         ST_SHIFT: begin
            if (walk_end) begin
               state_in = ST_SHIFT_LAST;
            end
         end
         ST_SHIFT_LAST: begin
            state_in = op_ins_ff ? ST_PUT : ST_RESP;
         end
         ST_PUT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_OUT;
         end
         ST_WALK_OUT: begin
            if (out_free) begin
               state_in = walk_end ? ST_IDLE : ST_WALK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs: memory port and output load
   always_comb begin
      mem_wr_en      = 1'b0;
      mem_wr_addr    = wr_addr_ff;
      mem_wr_data    = mem_rd_data;
      mem_rd_en      = 1'b0;
      rsp_load       = 1'b0;
      rsp_load_value = '0;
      rsp_load_has   = 1'b0;
      rsp_load_last  = 1'b1;
      unique case (state_ff)
         ST_SHIFT: begin
            mem_rd_en = 1'b1;
            mem_wr_en = pend_ff;
         end
         ST_SHIFT_LAST: begin
            mem_wr_en = 1'b1;
         end
         ST_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = put_idx_ff;
            mem_wr_data = value_ff;
         end
         ST_RESP: begin
            rsp_load = out_free;
         end
         ST_WALK_RD: begin
            mem_rd_en = 1'b1;
         end
         ST_WALK_OUT: begin
            rsp_load       = out_free;
            rsp_load_value = mem_rd_data;
            rsp_load_has   = 1'b1;
            rsp_load_last  = walk_end;
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      count_in   = count_ff;
      op_ins_in  = op_ins_ff;
      rd_idx_in  = rd_idx_ff;
      stop_in    = stop_ff;
      put_idx_in = put_idx_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      pend_in    = 1'b0;
      wr_addr_in = wr_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               count_in   = d_count;
               op_ins_in  = d_ins;
               rd_idx_in  = d_rd_start;
               stop_in    = d_stop;
               put_idx_in = d_put;
               value_in   = req_item_value;
               status_in  = d_status;
            end
         end
         ST_SHIFT: begin
            // entry read now is written one place up (insert) or down (delete) in the next cycle
            pend_in = 1'b1;
            if (op_ins_ff) begin
               wr_addr_in = rd_idx_ff + AW'(1);
               rd_idx_in  = rd_idx_ff - AW'(1);
            end else begin
               wr_addr_in = rd_idx_ff - AW'(1);
               rd_idx_in  = rd_idx_ff + AW'(1);
            end
         end
         ST_WALK_OUT: begin
            if (out_free) begin
               rd_idx_in = rd_idx_ff + AW'(1);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ins_ff  <= op_ins_in;
      rd_idx_ff  <= rd_idx_in;
      stop_ff    <= stop_in;
      put_idx_ff <= put_idx_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      wr_addr_ff <= wr_addr_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= rsp_load_value;
         rsp_has_ff    <= rsp_load_has;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= rsp_load_has ? STAT_DONE : status_ff;
         rsp_last_ff   <= rsp_load_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_has_value   = rsp_has_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire
